// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers; every use samples on clk and is muted while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bpa_pkg.sv =====
package bpa_pkg;

  localparam int PAGE_COUNT_DEF = 1024;
  localparam int MAX_ORDER_DEF  = 11;

  // request operations
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_ADD   = 2'd2;

  // result status
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  // datapath steps, one per controller state
  typedef struct packed {
    logic clear;
    logic load;
    logic pool;
    logic search;
    logic u0;
    logic u1;
    logic u2;
    logic split;
    logic mark;
    logic p0;
    logic p1;
    logic frd;
    logic fchk;
    logic mrd;
    logic mchk;
    logic fend;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic req_bad;
    logic req_alloc;
    logic req_add;
    logic cur_alloc;
    logic clr_last;
    logic pool_last;
    logic found;
    logic lvl_last;
    logic split_more;
    logic split_bud_ok;
    logic mark_last;
    logic dbl;
    logic merge_go;
    logic merge_ok;
  } sts_t;

endpackage

// ===== hw/rtl/bpa_datapath.sv =====
module bpa_datapath #(
  parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF,
  parameter int MAX_ORDER  = bpa_pkg::MAX_ORDER_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    s_op,
  input  logic [3:0]    s_order,
  input  logic [9:0]    s_page,
  input  bpa_pkg::cmd_t cmd,
  output bpa_pkg::sts_t sts,
  output logic [1:0]    res_status,
  output logic [9:0]    res_block
);

  localparam int AW = $clog2(PAGE_COUNT);
  localparam int LW = $clog2(PAGE_COUNT + 1);
  localparam int OW = $clog2(MAX_ORDER + 1);
  localparam int HW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int BW = (LW > MAX_ORDER) ? LW : MAX_ORDER;
  localparam int WW = BW + 1;
  localparam logic [LW-1:0] NIL  = LW'(PAGE_COUNT);
  localparam logic [WW-1:0] PC_W = WW'(PAGE_COUNT);

  logic [1:0]    op;
  logic [OW-1:0] ord;
  logic [OW-1:0] tord;
  logic [OW-1:0] lvl;
  logic [LW-1:0] pg;
  logic [LW-1:0] got;
  logic [LW-1:0] bud;
  logic [LW-1:0] ux;
  logic [OW-1:0] uo;
  logic [LW-1:0] mx;
  logic [OW-1:0] mo;
  logic          mf;
  logic [LW-1:0] first;
  logic [WW-1:0] cnt;
  logic [1:0]    res_st;
  logic [LW-1:0] res_blk;

  logic [LW-1:0]   list_head [MAX_ORDER];
  logic [OW+1:0]   attr_mem  [PAGE_COUNT];
  logic            pool_mem  [PAGE_COUNT];
  logic [LW-1:0]   next_mem  [PAGE_COUNT];
  logic [LW-1:0]   prev_mem  [PAGE_COUNT];

  logic [OW+1:0] attr_rd;
  logic          pool_rd;
  logic [LW-1:0] next_rd;
  logic [LW-1:0] prev_rd;

  logic [OW-1:0] hd_ra;
  logic [LW-1:0] hd_rd;
  logic [OW-1:0] lvl_m1;
  logic [WW-1:0] bud_s;
  logic [WW-1:0] bud_m;
  logic [WW-1:0] mark_sum;
  logic [WW-1:0] pool_sum;
  logic [AW-1:0] rd_a;

  logic          a_we;
  logic [AW-1:0] a_wa;
  logic [OW+1:0] a_wd;
  logic          p_we;
  logic [AW-1:0] p_wa;
  logic          p_wd;
  logic          n_we;
  logic [AW-1:0] n_wa;
  logic [LW-1:0] n_wd;
  logic          v_we;
  logic [AW-1:0] v_wa;
  logic [LW-1:0] v_wd;

  // attribute word: head, free, order
  logic          a_head;
  logic          a_free;
  logic [OW-1:0] a_ord;
  assign a_head = attr_rd[OW+1];
  assign a_free = attr_rd[OW];
  assign a_ord  = attr_rd[OW-1:0];

  assign hd_ra    = cmd.p0 ? mo : lvl;
  assign hd_rd    = list_head[hd_ra[HW-1:0]];
  assign lvl_m1   = lvl - OW'(1);
  assign bud_s    = WW'(got) ^ (WW'(1) << lvl_m1);
  assign bud_m    = WW'(pg) ^ (WW'(1) << ord);
  assign mark_sum = WW'(mx) + cnt;
  assign pool_sum = WW'(pg) + cnt;
  assign rd_a     = cmd.frd ? pg[AW-1:0] : bud_m[AW-1:0];

  always_comb begin
    sts.req_bad = (s_op != bpa_pkg::OP_ALLOC && s_op != bpa_pkg::OP_FREE &&
                   s_op != bpa_pkg::OP_ADD) || (32'(s_order) >= MAX_ORDER) ||
                  (s_op != bpa_pkg::OP_ALLOC && 32'(s_page) >= PAGE_COUNT);
    sts.req_alloc    = s_op == bpa_pkg::OP_ALLOC;
    sts.req_add      = s_op == bpa_pkg::OP_ADD;
    sts.cur_alloc    = op == bpa_pkg::OP_ALLOC;
    sts.clr_last     = cnt == PC_W - WW'(1);
    sts.pool_last    = (cnt + WW'(1) == (WW'(1) << ord)) || (pool_sum + WW'(1) >= PC_W);
    sts.found        = hd_rd != NIL;
    sts.lvl_last     = 32'(lvl) + 1 >= MAX_ORDER;
    sts.split_more   = lvl > tord;
    sts.split_bud_ok = bud_s < PC_W;
    sts.mark_last    = (cnt + WW'(1) == (WW'(1) << mo)) || (mark_sum + WW'(1) >= PC_W);
    sts.dbl          = a_head && a_free;
    sts.merge_go     = (32'(ord) + 1 < MAX_ORDER) && (bud_m < PC_W);
    sts.merge_ok     = pool_rd && a_head && a_free && (a_ord == ord);
  end

  // memory write selection
  always_comb begin
    a_we = cmd.clear || cmd.mark;
    a_wa = cmd.clear ? cnt[AW-1:0] : mark_sum[AW-1:0];
    a_wd = cmd.clear ? '0 : {cnt == '0, mf, mo};

    p_we = cmd.clear || cmd.pool;
    p_wa = cmd.clear ? cnt[AW-1:0] : pool_sum[AW-1:0];
    p_wd = cmd.pool;

    n_we = 1'b0;
    n_wa = ux[AW-1:0];
    n_wd = NIL;
    if (cmd.u1 && prev_rd != NIL) begin
      n_we = 1'b1;
      n_wa = prev_rd[AW-1:0];
      n_wd = next_rd;
    end else if (cmd.u2) begin
      n_we = 1'b1;
    end else if (cmd.p0) begin
      n_we = 1'b1;
      n_wa = mx[AW-1:0];
      n_wd = hd_rd;
    end

    v_we = 1'b0;
    v_wa = ux[AW-1:0];
    v_wd = NIL;
    if (cmd.u1 && next_rd != NIL) begin
      v_we = 1'b1;
      v_wa = next_rd[AW-1:0];
      v_wd = prev_rd;
    end else if (cmd.u2) begin
      v_we = 1'b1;
    end else if (cmd.p0) begin
      v_we = 1'b1;
      v_wa = mx[AW-1:0];
    end else if (cmd.p1 && first != NIL) begin
      v_we = 1'b1;
      v_wa = first[AW-1:0];
      v_wd = mx;
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) attr_mem[a_wa] <= a_wd;
    attr_rd <= attr_mem[rd_a];
  end

  always_ff @(posedge clk) begin
    if (p_we) pool_mem[p_wa] <= p_wd;
    pool_rd <= pool_mem[rd_a];
  end

  always_ff @(posedge clk) begin
    if (n_we) next_mem[n_wa] <= n_wd;
    next_rd <= next_mem[ux[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (v_we) prev_mem[v_wa] <= v_wd;
    prev_rd <= prev_mem[ux[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ORDER; i++) list_head[i] <= NIL;
    end else if (cmd.u1 && prev_rd == NIL) begin
      list_head[uo[HW-1:0]] <= next_rd;
    end else if (cmd.p0) begin
      list_head[mo[HW-1:0]] <= mx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load || cmd.split || cmd.fend) begin
      cnt <= '0;
    end else if (cmd.clear) begin
      cnt <= sts.clr_last ? '0 : cnt + WW'(1);
    end else if (cmd.pool) begin
      cnt <= sts.pool_last ? '0 : cnt + WW'(1);
    end else if (cmd.mark) begin
      cnt <= cnt + WW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= s_op;
      ord     <= OW'(s_order);
      tord    <= OW'(s_order);
      lvl     <= OW'(s_order);
      pg      <= LW'(s_page);
      res_st  <= sts.req_bad ? bpa_pkg::ST_BAD : bpa_pkg::ST_DONE;
      res_blk <= '0;
    end
    if (cmd.search) begin
      if (sts.found) begin
        got <= hd_rd;
        ux  <= hd_rd;
        uo  <= lvl;
      end else if (sts.lvl_last) begin
        res_st <= bpa_pkg::ST_NOSPACE;
      end else begin
        lvl <= lvl + OW'(1);
      end
    end
    if (cmd.split) begin
      if (sts.split_more) begin
        lvl <= lvl_m1;
        mx  <= bud_s[LW-1:0];
        mo  <= lvl_m1;
        mf  <= 1'b1;
      end else begin
        mx      <= got;
        mo      <= tord;
        mf      <= 1'b0;
        res_blk <= got;
      end
    end
    if (cmd.p0) first <= hd_rd;
    if (cmd.fchk) begin
      ux <= pg;
      uo <= a_ord;
    end
    if (cmd.mrd) bud <= bud_m[LW-1:0];
    // take the buddy off its list and grow the block
    if (cmd.mchk && sts.merge_ok) begin
      ux  <= bud;
      uo  <= ord;
      ord <= ord + OW'(1);
      if (bud < pg) pg <= bud;
    end
    if (cmd.fend) begin
      mx      <= pg;
      mo      <= ord;
      mf      <= 1'b1;
      res_blk <= pg;
    end
    if (cmd.fin) begin
      res_status <= res_st;
      res_block  <= 10'(res_blk);
    end
  end

endmodule

// ===== hw/rtl/bpa_ctrl.sv =====
module bpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  bpa_pkg::sts_t sts,
  output bpa_pkg::cmd_t cmd
);

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_POOL   = 5'd2;
  localparam logic [4:0] S_SEARCH = 5'd3;
  localparam logic [4:0] S_U0     = 5'd4;
  localparam logic [4:0] S_U1     = 5'd5;
  localparam logic [4:0] S_U2     = 5'd6;
  localparam logic [4:0] S_SPLIT  = 5'd7;
  localparam logic [4:0] S_MARK   = 5'd8;
  localparam logic [4:0] S_P0     = 5'd9;
  localparam logic [4:0] S_P1     = 5'd10;
  localparam logic [4:0] S_FRD    = 5'd11;
  localparam logic [4:0] S_FCHK   = 5'd12;
  localparam logic [4:0] S_MRD    = 5'd13;
  localparam logic [4:0] S_MCHK   = 5'd14;
  localparam logic [4:0] S_FEND   = 5'd15;
  localparam logic [4:0] S_FIN    = 5'd16;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       last_mark;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    cmd.clear  = state == S_CLR;
    cmd.load   = state == S_IDLE && in_valid;
    cmd.pool   = state == S_POOL;
    cmd.search = state == S_SEARCH;
    cmd.u0     = state == S_U0;
    cmd.u1     = state == S_U1;
    cmd.u2     = state == S_U2;
    cmd.split  = state == S_SPLIT;
    cmd.mark   = state == S_MARK;
    cmd.p0     = state == S_P0;
    cmd.p1     = state == S_P1;
    cmd.frd    = state == S_FRD;
    cmd.fchk   = state == S_FCHK;
    cmd.mrd    = state == S_MRD;
    cmd.mchk   = state == S_MCHK;
    cmd.fend   = state == S_FEND;
    cmd.fin    = state == S_FIN && (!out_valid || out_ready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:    if (sts.clr_last) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          if (sts.req_bad)        state_next = S_FIN;
          else if (sts.req_alloc) state_next = S_SEARCH;
          else if (sts.req_add)   state_next = S_POOL;
          else                    state_next = S_FRD;
        end
      end
      S_POOL:   if (sts.pool_last) state_next = S_FRD;
      S_SEARCH: begin
        if (sts.found)         state_next = S_U0;
        else if (sts.lvl_last) state_next = S_FIN;
      end
      S_U0:     state_next = S_U1;
      S_U1:     state_next = S_U2;
      S_U2:     state_next = sts.cur_alloc ? S_SPLIT : S_MRD;
      S_SPLIT: begin
        if (!sts.split_more || sts.split_bud_ok) state_next = S_MARK;
      end
      S_MARK: begin
        if (sts.mark_last) state_next = (sts.cur_alloc && last_mark) ? S_FIN : S_P0;
      end
      S_P0:     state_next = S_P1;
      S_P1:     state_next = sts.cur_alloc ? S_SPLIT : S_FIN;
      S_FRD:    state_next = S_FCHK;
      S_FCHK:   state_next = sts.dbl ? S_U0 : S_MRD;
      S_MRD:    state_next = sts.merge_go ? S_MCHK : S_FEND;
      S_MCHK:   state_next = sts.merge_ok ? S_U0 : S_FEND;
      S_FEND:   state_next = S_MARK;
      S_FIN:    if (cmd.fin) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      last_mark <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) last_mark <= 1'b0;
      else if (cmd.split && !sts.split_more) last_mark <= 1'b1;
      if (cmd.fin) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/buddy_page_allocator.sv =====
// One item at a time; the next is taken once the previous result is loaded.
// Allocate: searches the lists upward from the order, unlinks the block found, splits it down.
// Free: checks for a double free, merges with each free buddy, then marks and lists the block;
//   an add first sets the pool bits of its pages; marks a page a cycle.
// Synchronous reset empties every free list, then a clearing pass over every page
//   zeroes the page attributes; no item is accepted until it ends.
module buddy_page_allocator #(
  parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF,
  parameter int MAX_ORDER  = bpa_pkg::MAX_ORDER_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // order [3:0], page_index [13:4]
  input  logic [1:0]  s_axis_tuser,   // operation [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // block_index [9:0]
  output logic [1:0]  m_axis_tuser    // status [1:0]
);

  `include "assert_macros.svh"

  bpa_pkg::cmd_t cmd;
  bpa_pkg::sts_t sts;
  logic [9:0]    res_block;
  logic          in_take;
  logic          res_failed;
  logic          st_known;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpa_datapath #(
    .PAGE_COUNT (PAGE_COUNT),
    .MAX_ORDER  (MAX_ORDER)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .s_op       (s_axis_tuser),
    .s_order    (s_axis_tdata[3:0]),
    .s_page     (s_axis_tdata[13:4]),
    .cmd        (cmd),
    .sts        (sts),
    .res_status (m_axis_tuser),
    .res_block  (res_block)
  );

  assign m_axis_tdata = {6'd0, res_block};

  assign in_take    = s_axis_tvalid && s_axis_tready;
  assign res_failed = m_axis_tvalid && m_axis_tuser != bpa_pkg::ST_DONE;
  assign st_known   = m_axis_tuser == bpa_pkg::ST_DONE || m_axis_tuser == bpa_pkg::ST_NOSPACE ||
                      m_axis_tuser == bpa_pkg::ST_BAD;

  `CHECK_NEXT(a_one_at_a_time, in_take, !s_axis_tready, "item taken while busy")
  `CHECK_NOW(a_fail_zero_index, res_failed, m_axis_tdata == 16'd0, "failed result has an index")
  `CHECK_NOW(a_status_code, m_axis_tvalid, st_known, "unknown status")

endmodule

// ===== tb/buddy_page_allocator_test.sv =====
`default_nettype none

module buddy_page_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bpa_pkg::*;

  localparam int NPAGES = PAGE_COUNT_DEF;
  localparam int NORDERS = MAX_ORDER_DEF;
  localparam int NONE = NPAGES;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam int IDLE_LIMIT = 40000;
  localparam int RANDOM_ITEMS = 925;

  typedef struct {
    logic [1:0] status;
    logic [9:0] block;
  } outcome_t;

  typedef struct {
    int page;
    int ord;
  } held_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // order [3:0], page_index [13:4]
  logic [1:0]  s_axis_tuser;   // operation [1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // block_index [9:0]
  logic [1:0]  m_axis_tuser;   // status [1:0]

  buddy_page_allocator dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  // allocator mirror
  int free_head [NORDERS];
  int link_next [NPAGES];
  int link_prev [NPAGES];
  int blk_order [NPAGES];
  bit is_free [NPAGES];
  bit is_head [NPAGES];
  bit in_pool [NPAGES];

  outcome_t pending_results[$];
  held_t held[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void push_free(int pg, int ord);
    int first;
    if (pg >= NONE || ord >= NORDERS) return;
    first = free_head[ord];
    link_prev[pg] = NONE;
    link_next[pg] = first;
    if (first < NONE) link_prev[first] = pg;
    free_head[ord] = pg;
  endfunction

  function automatic void unlink_free(int pg, int ord);
    int pv;
    int nx;
    if (pg >= NONE) return;
    pv = link_prev[pg];
    nx = link_next[pg];
    if (pv < NONE) link_next[pv] = nx;
    else if (ord < NORDERS) free_head[ord] = nx;
    if (nx < NONE) link_prev[nx] = pv;
    link_next[pg] = NONE;
    link_prev[pg] = NONE;
  endfunction

  function automatic void mark_pages(int pg, int ord, bit free_now);
    for (int i = 0; i < (1 << ord) && pg + i < NONE; i++) begin
      is_free[pg + i] = free_now;
      blk_order[pg + i] = ord;
      is_head[pg + i] = 1'b0;
    end
    if (pg < NONE) is_head[pg] = 1'b1;
  endfunction

  function automatic int release_block(int pg, int ord);
    int bud;
    if (is_head[pg] && is_free[pg]) unlink_free(pg, blk_order[pg]);
    while (ord + 1 < NORDERS) begin
      bud = pg ^ (1 << ord);
      if (bud >= NONE || !in_pool[bud] || !is_head[bud] || !is_free[bud] ||
          blk_order[bud] != ord) break;
      unlink_free(bud, ord);
      if (bud < pg) begin
        is_head[pg] = 1'b0;
        pg = bud;
      end
      ord++;
    end
    mark_pages(pg, ord, 1'b1);
    push_free(pg, ord);
    return pg;
  endfunction

  function automatic outcome_t serve_request(logic [1:0] op, int ord, int pg);
    outcome_t r;
    int lvl;
    int got;
    r.status = ST_DONE;
    r.block = '0;
    if (op == OP_UNKNOWN || ord >= NORDERS || (op != OP_ALLOC && pg >= NONE)) begin
      r.status = ST_BAD;
    end else if (op == OP_ALLOC) begin
      lvl = ord;
      got = NONE;
      while (lvl < NORDERS) begin
        if (free_head[lvl] < NONE) begin
          got = free_head[lvl];
          unlink_free(got, lvl);
          break;
        end
        lvl++;
      end
      if (got >= NONE) begin
        r.status = ST_NOSPACE;
      end else begin
        // hand the upper halves back, largest first
        while (lvl > ord) begin
          lvl--;
          if ((got ^ (1 << lvl)) < NONE) begin
            mark_pages(got ^ (1 << lvl), lvl, 1'b1);
            push_free(got ^ (1 << lvl), lvl);
          end
        end
        mark_pages(got, ord, 1'b0);
        r.block = got[9:0];
      end
    end else begin
      if (op == OP_ADD)
        for (int i = 0; i < (1 << ord) && pg + i < NONE; i++) in_pool[pg + i] = 1'b1;
      r.block = 10'(release_block(pg, ord));
    end
    return r;
  endfunction

  task automatic send_item(logic [1:0] op, logic [3:0] ord, logic [9:0] pg);
    outcome_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, pg, ord};
    s_axis_tuser <= op;
    do @(posedge clk); while (!s_axis_tready);
    r = serve_request(op, int'(ord), int'(pg));
    pending_results.push_back(r);
    if (op == OP_ALLOC && r.status == ST_DONE) held.push_back('{int'(r.block), int'(ord)});
  endtask

  // receiver stall pattern: phases of full, patchy and sparse readiness
  int ready_pct = 100;
  int phase_cnt = 0;
  always @(posedge clk) begin
    if (phase_cnt == 0) begin
      phase_cnt <= $urandom_range(50, 400);
      case ($urandom_range(0, 2))
        0: ready_pct <= 100;
        1: ready_pct <= 60;
        default: ready_pct <= 15;
      endcase
    end else begin
      phase_cnt <= phase_cnt - 1;
    end
    m_axis_tready <= ($urandom_range(0, 99) < ready_pct);
  end

  always @(posedge clk) begin
    outcome_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d block %0d", $time, m_axis_tuser,
                 m_axis_tdata[9:0]);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (m_axis_tuser !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[9:0] !== e.block) begin
          $display("%0t: block_index expected %0d actual %0d", $time, e.block,
                   m_axis_tdata[9:0]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("buddy_page_allocator regression: fail");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(OP_ALLOC, 4'd0, 10'd0);      // empty pool
    send_item(OP_ADD, 4'd10, 10'd0);       // whole array
    send_item(OP_ALLOC, 4'd0, 10'd1023);   // split through every level
    send_item(OP_ALLOC, 4'd10, 10'd0);     // nothing large enough
    send_item(OP_FREE, 4'd0, 10'd0);       // merge back to one block
    send_item(OP_ALLOC, 4'd10, 10'd0);
    send_item(OP_FREE, 4'd10, 10'd0);
    send_item(OP_ALLOC, 4'd11, 10'd0);     // order too large
    send_item(OP_FREE, 4'd15, 10'd1023);
    send_item(OP_ADD, 4'd12, 10'd5);
    send_item(OP_UNKNOWN, 4'd0, 10'd0);
    send_item(OP_UNKNOWN, 4'd15, 10'h3ff);
    send_item(OP_ALLOC, 4'd2, 10'd0);
    send_item(OP_FREE, 4'd2, 10'd4);       // double free of a free head
    send_item(OP_FREE, 4'd2, 10'd4);
    send_item(OP_ALLOC, 4'd3, 10'd0);
    send_item(OP_ADD, 4'd4, 10'd1020);     // block runs past the end
    send_item(OP_ALLOC, 4'd1, 10'd0);
    send_item(OP_FREE, 4'd0, 10'd1023);
    send_item(OP_ALLOC, 4'd0, 10'd0);
    held.delete();
  endtask

  task automatic test_random();
    int pick;
    int ord;
    int idx;
    held_t h;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      ord = ($urandom_range(0, 49) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 4);
      if (pick < 38) begin
        send_item(OP_ALLOC, 4'(ord), 10'($urandom));
      end else if (pick < 75 && held.size() > 0) begin
        idx = $urandom_range(0, held.size() - 1);
        h = held[idx];
        held.delete(idx);
        send_item(OP_FREE, 4'(h.ord), 10'(h.page));
      end else if (pick < 85) begin
        // aligned add of a random region
        send_item(OP_ADD, 4'(ord), 10'(($urandom_range(0, 1023) >> ord) << ord));
      end else if (pick < 92) begin
        // stray free, possibly unaligned or doubled
        send_item(OP_FREE, 4'($urandom_range(0, 5)), 10'($urandom));
      end else if (pick < 96) begin
        send_item(2'($urandom_range(0, 2)), 4'($urandom_range(11, 15)), 10'($urandom));
      end else begin
        send_item(OP_UNKNOWN, 4'($urandom), 10'($urandom));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= OP_ALLOC;
    for (int o = 0; o < NORDERS; o++) free_head[o] = NONE;
    for (int p = 0; p < NPAGES; p++) begin
      link_next[p] = 0;
      link_prev[p] = 0;
      blk_order[p] = 0;
      is_free[p] = 1'b0;
      is_head[p] = 1'b0;
      in_pool[p] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("buddy_page_allocator regression: pass");
    end else begin
      $display("buddy_page_allocator regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== buddy_page_allocator.f =====
+incdir+hw/rtl
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_datapath.sv
hw/rtl/bpa_ctrl.sv
hw/rtl/buddy_page_allocator.sv
tb/buddy_page_allocator_test.sv
